### src/fcs_pkg.sv
// ----------------------------------------------------------------------------
// Flash command sequencer package
// Shared types, bus constants and the microcode table that drives the
// sequencer's datapath.
// ----------------------------------------------------------------------------
package fcs_pkg;

   localparam int ADDR_FIELD_WIDTH   = 19;
   localparam int ADDR_WIDTH_DEFAULT = 19;
   localparam int WAIT_WIDTH         = 10;
   localparam int STEP_WIDTH         = 3;
   localparam int CSR_INDEX_WIDTH    = 1;

   typedef logic [ADDR_FIELD_WIDTH-1:0] addr_type;
   typedef logic [WAIT_WIDTH-1:0]       wait_type;
   typedef logic [7:0]                  byte_type;
   typedef logic [STEP_WIDTH-1:0]       step_type;

   // Unlock addresses and command codes of the software data protection scheme.
   localparam addr_type UNLOCK_ADDR_HI    = 19'h05555;
   localparam addr_type UNLOCK_ADDR_LO    = 19'h02AAA;
   localparam byte_type UNLOCK_CODE_1     = 8'hAA;
   localparam byte_type UNLOCK_CODE_2     = 8'h55;
   localparam byte_type PROGRAM_CODE      = 8'hA0;
   localparam byte_type ERASE_SETUP_CODE  = 8'h80;
   localparam byte_type SECTOR_ERASE_CODE = 8'h30;
   localparam byte_type CHIP_ERASE_CODE   = 8'h10;
   localparam byte_type DATA_ZERO         = 8'h00;

   localparam wait_type SECTOR_WAIT_RESET = 10'd25;
   localparam wait_type CHIP_WAIT_RESET   = 10'd100;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECTOR_WAIT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHIP_WAIT   = 1'b1;

   typedef enum logic [1:0] {
      ACT_CHIP_ERASE   = 2'd0,
      ACT_PROGRAM      = 2'd1,
      ACT_READ         = 2'd2,
      ACT_SECTOR_ERASE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WAIT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ASEL_ZERO = 2'd0,
      ASEL_5555 = 2'd1,
      ASEL_2AAA = 2'd2,
      ASEL_HELD = 2'd3
   } addr_sel_type;

   typedef enum logic [1:0] {
      DSEL_ZERO  = 2'd0,
      DSEL_CONST = 2'd1,
      DSEL_HELD  = 2'd2
   } data_sel_type;

   typedef enum logic [1:0] {
      WSEL_NONE   = 2'd0,
      WSEL_SECTOR = 2'd1,
      WSEL_CHIP   = 2'd2
   } wait_sel_type;

   // One control word per step. The last flag ends the program and returns
   // the sequencer to idle.
   typedef struct packed {
      kind_type     kind;
      addr_sel_type addr_sel;
      data_sel_type data_sel;
      byte_type     data;
      wait_sel_type wait_sel;
      logic         last;
   } ucode_type;

   typedef struct packed {
      logic       load;
      ucode_type  ucode;
      addr_type   address;
      byte_type   data;
   } ctrl_type;

   typedef struct packed {
      logic [1:0] action;
      addr_type   target_address;
      byte_type   write_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] cycle_kind;
      addr_type   bus_address;
      byte_type   bus_data;
      wait_type   wait_ms;
      logic       last;
   } rsp_type;

   function automatic ucode_type unlock(input addr_sel_type sel, input byte_type code);
      ucode_type w;
      w.kind     = KIND_WRITE;
      w.addr_sel = sel;
      w.data_sel = DSEL_CONST;
      w.data     = code;
      w.wait_sel = WSEL_NONE;
      w.last     = 1'b0;
      return w;
   endfunction

   function automatic ucode_type busy_wait(input wait_sel_type sel);
      ucode_type w;
      w.kind     = KIND_WAIT;
      w.addr_sel = ASEL_ZERO;
      w.data_sel = DSEL_ZERO;
      w.data     = DATA_ZERO;
      w.wait_sel = sel;
      w.last     = 1'b1;
      return w;
   endfunction

   function automatic ucode_type final_access(input kind_type kind, input data_sel_type dsel);
      ucode_type w;
      w.kind     = kind;
      w.addr_sel = ASEL_HELD;
      w.data_sel = dsel;
      w.data     = DATA_ZERO;
      w.wait_sel = WSEL_NONE;
      w.last     = 1'b1;
      return w;
   endfunction

   // Microcode table, addressed by the held action and the step counter.
   function automatic ucode_type ucode_rom(input action_type action, input step_type step);
      ucode_type w;
      w = final_access(KIND_READ, DSEL_ZERO);
      unique case (action)
         ACT_READ: begin
            w = final_access(KIND_READ, DSEL_ZERO);
         end
         ACT_PROGRAM: begin
            case (step)
               3'd0:    w = unlock(ASEL_5555, UNLOCK_CODE_1);
               3'd1:    w = unlock(ASEL_2AAA, UNLOCK_CODE_2);
               3'd2:    w = unlock(ASEL_5555, PROGRAM_CODE);
               default: w = final_access(KIND_WRITE, DSEL_HELD);
            endcase
         end
         ACT_CHIP_ERASE, ACT_SECTOR_ERASE: begin
            case (step)
               3'd0: w = unlock(ASEL_5555, UNLOCK_CODE_1);
               3'd1: w = unlock(ASEL_2AAA, UNLOCK_CODE_2);
               3'd2: w = unlock(ASEL_5555, ERASE_SETUP_CODE);
               3'd3: w = unlock(ASEL_5555, UNLOCK_CODE_1);
               3'd4: w = unlock(ASEL_2AAA, UNLOCK_CODE_2);
               3'd5: begin
                  if (action == ACT_CHIP_ERASE) begin
                     w = unlock(ASEL_5555, CHIP_ERASE_CODE);
                  end else begin
                     w = unlock(ASEL_HELD, SECTOR_ERASE_CODE);
                  end
               end
               default: begin
                  if (action == ACT_CHIP_ERASE) begin
                     w = busy_wait(WSEL_CHIP);
                  end else begin
                     w = busy_wait(WSEL_SECTOR);
                  end
               end
            endcase
         end
      endcase
      return w;
   endfunction

endpackage

### src/flash_command_sequencer_top.sv
// A taken command is held in the sequencer registers, then its first bus word is registered.
// Throughput: one word per cycle while the result side takes them; a read has one microcode step,
// a byte program four and an erase seven, which the step counter walks through the microcode table.
// The next command is taken in the cycle the final word of the current one is issued.
// Reset is synchronous and active high: it clears the sequencer to idle, empties the
// output register and loads the wait registers with 25 ms and 100 ms.
// ----------------------------------------------------------------------------
// Flash command sequencer
// Turns one flash command into the parallel-flash bus cycles that carry it.
// ----------------------------------------------------------------------------
module flash_command_sequencer_top #(
   parameter int ADDR_WIDTH = fcs_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fcs_pkg::req_type                      req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fcs_pkg::rsp_type                      rsp_word,
   input  logic                                  csr_write_en,
   input  logic [fcs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  fcs_pkg::wait_type                     csr_wdata
);

   fcs_pkg::ctrl_type ctrl;
   logic              out_ready;

   fcs_sequencer #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_ready (out_ready),
      .ctrl      (ctrl)
   );

   fcs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .out_ready    (out_ready),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule

### src/fcs_sequencer.sv
// ----------------------------------------------------------------------------
// Flash command sequencer control
// Holds the accepted command, walks the step counter through the microcode
// table and hands one control word per bus cycle to the datapath.
// ----------------------------------------------------------------------------
module fcs_sequencer #(
   parameter int ADDR_WIDTH = fcs_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcs_pkg::req_type  req_word,
   input  logic              out_ready,
   output fcs_pkg::ctrl_type ctrl
);

   localparam int HELD_WIDTH = (ADDR_WIDTH < fcs_pkg::ADDR_FIELD_WIDTH) ?
                               ADDR_WIDTH : fcs_pkg::ADDR_FIELD_WIDTH;

   logic                    busy_ff, busy_in;
   fcs_pkg::step_type       step_ff, step_in;
   fcs_pkg::action_type     action_ff, action_in;
   logic [HELD_WIDTH-1:0]   addr_ff, addr_in;
   fcs_pkg::byte_type       byte_ff, byte_in;

   fcs_pkg::ucode_type      ucode;
   logic                    advance;
   logic                    accept;

   assign ucode   = fcs_pkg::ucode_rom(action_ff, step_ff);
   assign advance = busy_ff & out_ready;
   // The next command may enter in the cycle the final word is issued.
   assign req_stall = busy_ff & ~(advance & ucode.last);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      action_in = action_ff;
      addr_in   = addr_ff;
      byte_in   = byte_ff;
      priority if (accept) begin
         busy_in   = 1'b1;
         step_in   = '0;
         action_in = fcs_pkg::action_type'(req_word.action);
         addr_in   = req_word.target_address[HELD_WIDTH-1:0];
         byte_in   = req_word.write_byte;
      end else if (advance) begin
         if (ucode.last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         step_ff   <= '0;
         action_ff <= fcs_pkg::ACT_CHIP_ERASE;
      end else begin
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         action_ff <= action_in;
      end
      addr_ff <= addr_in;
      byte_ff <= byte_in;
   end

   assign ctrl.load    = advance;
   assign ctrl.ucode   = ucode;
   assign ctrl.address = fcs_pkg::addr_type'(addr_ff);
   assign ctrl.data    = byte_ff;

`ifndef SYNTHESIS
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= 3'd6)
      else $error("step counter ran past the longest program");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && step_ff == 3'd0)
      else $error("accepted command did not start at the first step");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && ucode.last && !req_valid) |=> !busy_ff)
      else $error("sequencer stayed busy after the final word");
`endif

endmodule

### src/fcs_datapath.sv
// ----------------------------------------------------------------------------
// Flash command sequencer datapath
// Wait-length registers, field selection under the control word, and the
// output register of the bus-cycle channel.
// ----------------------------------------------------------------------------
module fcs_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcs_pkg::ctrl_type                     ctrl,
   output logic                                  out_ready,
   input  logic                                  csr_write_en,
   input  logic [fcs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  fcs_pkg::wait_type                     csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fcs_pkg::rsp_type                      rsp_word
);

   fcs_pkg::wait_type sector_wait_ff, sector_wait_in;
   fcs_pkg::wait_type chip_wait_ff, chip_wait_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fcs_pkg::rsp_type  rsp_word_ff, rsp_word_in;

   always_comb begin
      sector_wait_in = sector_wait_ff;
      chip_wait_in   = chip_wait_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            fcs_pkg::CSR_SECTOR_WAIT: sector_wait_in = csr_wdata;
            fcs_pkg::CSR_CHIP_WAIT:   chip_wait_in   = csr_wdata;
         endcase
      end
   end

   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_word_in            = rsp_word_ff;
      rsp_valid_in           = rsp_valid_ff & rsp_stall;
      if (ctrl.load) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.cycle_kind = ctrl.ucode.kind;
         rsp_word_in.last       = ctrl.ucode.last;
         unique case (ctrl.ucode.addr_sel)
            fcs_pkg::ASEL_ZERO: rsp_word_in.bus_address = '0;
            fcs_pkg::ASEL_5555: rsp_word_in.bus_address = fcs_pkg::UNLOCK_ADDR_HI;
            fcs_pkg::ASEL_2AAA: rsp_word_in.bus_address = fcs_pkg::UNLOCK_ADDR_LO;
            fcs_pkg::ASEL_HELD: rsp_word_in.bus_address = ctrl.address;
         endcase
         unique case (ctrl.ucode.data_sel)
            fcs_pkg::DSEL_CONST: rsp_word_in.bus_data = ctrl.ucode.data;
            fcs_pkg::DSEL_HELD:  rsp_word_in.bus_data = ctrl.data;
            default:             rsp_word_in.bus_data = fcs_pkg::DATA_ZERO;
         endcase
         unique case (ctrl.ucode.wait_sel)
            fcs_pkg::WSEL_SECTOR: rsp_word_in.wait_ms = sector_wait_ff;
            fcs_pkg::WSEL_CHIP:   rsp_word_in.wait_ms = chip_wait_ff;
            default:              rsp_word_in.wait_ms = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_wait_ff <= fcs_pkg::SECTOR_WAIT_RESET;
         chip_wait_ff   <= fcs_pkg::CHIP_WAIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sector_wait_ff <= sector_wait_in;
         chip_wait_ff   <= chip_wait_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> out_ready)
      else $error("control word issued while the output register was full");

   a_wait_only_on_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.cycle_kind != fcs_pkg::KIND_WAIT)
      |-> rsp_word_ff.wait_ms == '0)
      else $error("wait length driven on a bus access");

   a_busy_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.cycle_kind == fcs_pkg::KIND_WAIT)
      |-> rsp_word_ff.bus_address == '0 && rsp_word_ff.bus_data == '0 && rsp_word_ff.last)
      else $error("busy wait word carries address or data");
`endif

endmodule
